>>> sv/sts_pkg.sv
// package for the sine tone unit: state codes, divider handshake types
// and the 256-point sine table; used by every other file but sts_if
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam int DVD_W = 32;
  localparam int DVS_W = 16;
  localparam int CNT_W = $clog2(DVD_W);

  localparam int MS_PER_S = 1000;
  localparam logic [12:0] FREQ_MAX = 13'd8000;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_PER,
    S_RUN,
    S_IDX,
    S_POS,
    S_FIN,
    S_FINW,
    S_FOUT,
    S_FOUTW,
    S_STEP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  localparam logic signed [15:0] SINE_PTS [0:255] = '{
    16'sd0, 16'sd804, 16'sd1607, 16'sd2410, 16'sd3211, 16'sd4011, 16'sd4807, 16'sd5601,
    16'sd6392, 16'sd7179, 16'sd7961, 16'sd8739, 16'sd9511, 16'sd10278, 16'sd11038,
    16'sd11792, 16'sd12539, 16'sd13278, 16'sd14009, 16'sd14732, 16'sd15446, 16'sd16151,
    16'sd16845, 16'sd17530, 16'sd18204, 16'sd18867, 16'sd19519, 16'sd20159, 16'sd20787,
    16'sd21402, 16'sd22004, 16'sd22594, 16'sd23169, 16'sd23731, 16'sd24278, 16'sd24811,
    16'sd25329, 16'sd25831, 16'sd26318, 16'sd26789, 16'sd27244, 16'sd27683, 16'sd28105,
    16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621, 16'sd29955, 16'sd30272, 16'sd30571,
    16'sd30851, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785, 16'sd31971, 16'sd32137,
    16'sd32284, 16'sd32412, 16'sd32520, 16'sd32609, 16'sd32678, 16'sd32727, 16'sd32757,
    16'sd32767, 16'sd32757, 16'sd32727, 16'sd32678, 16'sd32609, 16'sd32520, 16'sd32412,
    16'sd32284, 16'sd32137, 16'sd31971, 16'sd31785, 16'sd31580, 16'sd31356, 16'sd31113,
    16'sd30851, 16'sd30571, 16'sd30272, 16'sd29955, 16'sd29621, 16'sd29268, 16'sd28898,
    16'sd28510, 16'sd28105, 16'sd27683, 16'sd27244, 16'sd26789, 16'sd26318, 16'sd25831,
    16'sd25329, 16'sd24811, 16'sd24278, 16'sd23731, 16'sd23169, 16'sd22594, 16'sd22004,
    16'sd21402, 16'sd20787, 16'sd20159, 16'sd19519, 16'sd18867, 16'sd18204, 16'sd17530,
    16'sd16845, 16'sd16151, 16'sd15446, 16'sd14732, 16'sd14009, 16'sd13278, 16'sd12539,
    16'sd11792, 16'sd11038, 16'sd10278, 16'sd9511, 16'sd8739, 16'sd7961, 16'sd7179,
    16'sd6392, 16'sd5601, 16'sd4807, 16'sd4011, 16'sd3211, 16'sd2410, 16'sd1607, 16'sd804,
    16'sd0, -16'sd804, -16'sd1607, -16'sd2410, -16'sd3211, -16'sd4011, -16'sd4807,
    -16'sd5601, -16'sd6392, -16'sd7179, -16'sd7961, -16'sd8739, -16'sd9511, -16'sd10278,
    -16'sd11038, -16'sd11792, -16'sd12539, -16'sd13278, -16'sd14009, -16'sd14732,
    -16'sd15446, -16'sd16151, -16'sd16845, -16'sd17530, -16'sd18204, -16'sd18867,
    -16'sd19519, -16'sd20159, -16'sd20787, -16'sd21402, -16'sd22004, -16'sd22594,
    -16'sd23169, -16'sd23731, -16'sd24278, -16'sd24811, -16'sd25329, -16'sd25831,
    -16'sd26318, -16'sd26789, -16'sd27244, -16'sd27683, -16'sd28105, -16'sd28510,
    -16'sd28898, -16'sd29268, -16'sd29621, -16'sd29955, -16'sd30272, -16'sd30571,
    -16'sd30851, -16'sd31113, -16'sd31356, -16'sd31580, -16'sd31785, -16'sd31971,
    -16'sd32137, -16'sd32284, -16'sd32412, -16'sd32520, -16'sd32609, -16'sd32678,
    -16'sd32727, -16'sd32757, -16'sd32767, -16'sd32757, -16'sd32727, -16'sd32678,
    -16'sd32609, -16'sd32520, -16'sd32412, -16'sd32284, -16'sd32137, -16'sd31971,
    -16'sd31785, -16'sd31580, -16'sd31356, -16'sd31113, -16'sd30851, -16'sd30571,
    -16'sd30272, -16'sd29955, -16'sd29621, -16'sd29268, -16'sd28898, -16'sd28510,
    -16'sd28105, -16'sd27683, -16'sd27244, -16'sd26789, -16'sd26318, -16'sd25831,
    -16'sd25329, -16'sd24811, -16'sd24278, -16'sd23731, -16'sd23169, -16'sd22594,
    -16'sd22004, -16'sd21402, -16'sd20787, -16'sd20159, -16'sd19519, -16'sd18867,
    -16'sd18204, -16'sd17530, -16'sd16845, -16'sd16151, -16'sd15446, -16'sd14732,
    -16'sd14009, -16'sd13278, -16'sd12539, -16'sd11792, -16'sd11038, -16'sd10278,
    -16'sd9511, -16'sd8739, -16'sd7961, -16'sd7179, -16'sd6392, -16'sd5601, -16'sd4807,
    -16'sd4011, -16'sd3211, -16'sd2410, -16'sd1607, -16'sd804
  };

endpackage

`default_nettype wire

>>> sv/sts_if.sv
// valid/ready channel interfaces for the sine tone unit: tick beats in,
// sample beats out; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sts_tick_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [12:0] freq_hz;
  logic [11:0] duration_ms;

  modport source (output valid, output action, output freq_hz, output duration_ms,
                  input ready);
  modport sink (input valid, input action, input freq_hz, input duration_ms,
                output ready);
endinterface

interface sts_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               note_done;

  modport source (output valid, output sample, output note_done, input ready);
  modport sink (input valid, input sample, input note_done, output ready);
endinterface

`default_nettype wire

>>> sv/sine_tone_with_fade_unit.sv
// top level of the sine tone unit: sequencer, note state and output register
// depends on sts_pkg, sts_if and sts_div
`timescale 1ns / 1ps
`default_nettype none

// Each tick beat yields one sample beat. A tick that advances a tone divides
// for the table index and the table rescale, and once more for each fade
// ramp that applies; a tick that starts a note first works out its length
// and, unless it is a rest, its period. A tick inside a rest and an idle
// tick need no divide. All of these share the one bit-serial divider, which
// does the length, period, table index, table rescale and both fade ramps
// in turn. A new tick is taken while the previous sample still waits in the
// output register; a sample that finds the register still occupied waits
// until that beat is taken.
module sine_tone_with_fade_unit #(
  parameter int SAMPLE_RATE_HZ = 16000,
  parameter int TABLE_SIZE     = 256,
  parameter int FADE_SAMPLES   = 128
) (
  input wire logic clk,
  input wire logic rst,
  sts_tick_if.sink tick,
  sts_res_if.source result
);
  import sts_pkg::*;

  localparam int PER_W = $clog2(SAMPLE_RATE_HZ + 1);
  localparam logic [DVD_W-1:0] SR_C   = DVD_W'(SAMPLE_RATE_HZ);
  localparam logic [DVD_W-1:0] TS_C   = DVD_W'(TABLE_SIZE);
  localparam logic [DVS_W-1:0] TS_DVS = DVS_W'(TABLE_SIZE);
  localparam logic [DVS_W-1:0] FD_DVS = DVS_W'(FADE_SAMPLES);
  localparam logic [DVS_W-1:0] MS_DVS = DVS_W'(MS_PER_S);
  localparam logic [16:0]      FD_17  = 17'(FADE_SAMPLES);

  state_t state, state_next;

  logic [PER_W-1:0] phase_count, phase_count_next;
  logic [PER_W-1:0] period_len, period_len_next;
  logic [15:0]      elapsed, elapsed_next;
  logic [15:0]      note_len, note_len_next;
  logic             rest_flag, rest_flag_next;
  logic             active, active_next;
  logic [12:0]      freq, freq_next;
  logic [14:0]      mag, mag_next;
  logic             neg, neg_next;
  logic [15:0]      smp, smp_next;
  logic             done, done_next;

  logic             div_start, div_start_next;
  logic [DVD_W-1:0] div_dvd, div_dvd_next;
  logic [DVS_W-1:0] div_dvs, div_dvs_next;

  logic             out_valid, out_valid_next;
  logic [15:0]      out_sample, out_sample_next;
  logic             out_done, out_done_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               take;
  logic               out_free;
  logic signed [15:0] tval;

  assign div_req.start    = div_start;
  assign div_req.dividend = div_dvd;
  assign div_req.divisor  = div_dvs;

  sts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign tick.ready      = (state == S_IDLE);
  assign take            = tick.valid && tick.ready;
  assign out_free        = !out_valid || result.ready;
  assign result.valid    = out_valid;
  assign result.sample   = out_sample;
  assign result.note_done = out_done;
  assign tval            = SINE_PTS[div_rsp.quotient[7:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase_count <= '0;
      period_len  <= '0;
      elapsed     <= '0;
      note_len    <= '0;
      rest_flag   <= 1'b0;
      active      <= 1'b0;
      div_start   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase_count <= phase_count_next;
      period_len  <= period_len_next;
      elapsed     <= elapsed_next;
      note_len    <= note_len_next;
      rest_flag   <= rest_flag_next;
      active      <= active_next;
      div_start   <= div_start_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    freq       <= freq_next;
    mag        <= mag_next;
    neg        <= neg_next;
    smp        <= smp_next;
    done       <= done_next;
    div_dvd    <= div_dvd_next;
    div_dvs    <= div_dvs_next;
    out_sample <= out_sample_next;
    out_done   <= out_done_next;
  end

  always_comb begin
    state_next       = state;
    phase_count_next = phase_count;
    period_len_next  = period_len;
    elapsed_next     = elapsed;
    note_len_next    = note_len;
    rest_flag_next   = rest_flag;
    active_next      = active;
    freq_next        = freq;
    mag_next         = mag;
    neg_next         = neg;
    smp_next         = smp;
    done_next        = done;
    div_start_next   = 1'b0;
    div_dvd_next     = div_dvd;
    div_dvs_next     = div_dvs;
    out_valid_next   = out_valid && !result.ready;
    out_sample_next  = out_sample;
    out_done_next    = out_done;

    case (state)
      S_IDLE: begin
        if (take) begin
          done_next = 1'b0;
          smp_next  = '0;
          if (tick.action) begin
            elapsed_next     = '0;
            phase_count_next = '0;
            rest_flag_next   = (tick.freq_hz == '0);
            freq_next        = (tick.freq_hz > FREQ_MAX) ? FREQ_MAX : tick.freq_hz;
            div_start_next   = 1'b1;
            div_dvd_next     = SR_C * DVD_W'(tick.duration_ms);
            div_dvs_next     = MS_DVS;
            state_next       = S_LEN;
          end else if (active) begin
            state_next = S_RUN;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_LEN: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > DVD_W'(LEN_MAX)) begin
            note_len_next = LEN_MAX;
          end else begin
            note_len_next = div_rsp.quotient[15:0];
          end
          active_next = (div_rsp.quotient != '0);
          if (div_rsp.quotient == '0) begin
            done_next = 1'b1;
          end
          if (rest_flag) begin
            period_len_next = '0;
            state_next      = (div_rsp.quotient != '0) ? S_RUN : S_OUT;
          end else begin
            div_start_next = 1'b1;
            div_dvd_next   = SR_C;
            div_dvs_next   = DVS_W'(freq);
            state_next     = S_PER;
          end
        end
      end
      S_PER: begin
        if (div_rsp.done) begin
          period_len_next = div_rsp.quotient[PER_W-1:0];
          state_next      = active ? S_RUN : S_OUT;
        end
      end
      S_RUN: begin
        if (rest_flag) begin
          mag_next   = '0;
          neg_next   = 1'b0;
          state_next = S_STEP;
        end else begin
          div_start_next = 1'b1;
          div_dvd_next   = DVD_W'(phase_count) * TS_C;
          div_dvs_next   = DVS_W'(period_len);
          state_next     = S_IDX;
        end
      end
      S_IDX: begin
        if (div_rsp.done) begin
          div_start_next = 1'b1;
          div_dvd_next   = {div_rsp.quotient[DVD_W-9:0], 8'd0};
          div_dvs_next   = TS_DVS;
          state_next     = S_POS;
        end
      end
      S_POS: begin
        if (div_rsp.done) begin
          neg_next   = tval[15];
          mag_next   = tval[15] ? 15'(-tval) : tval[14:0];
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (elapsed < 16'(FADE_SAMPLES)) begin
          div_start_next = 1'b1;
          div_dvd_next   = DVD_W'(mag) * DVD_W'(elapsed);
          div_dvs_next   = FD_DVS;
          state_next     = S_FINW;
        end else begin
          state_next = S_FOUT;
        end
      end
      S_FINW: begin
        if (div_rsp.done) begin
          mag_next   = div_rsp.quotient[14:0];
          state_next = S_FOUT;
        end
      end
      S_FOUT: begin
        if (({1'b0, elapsed} + FD_17) > {1'b0, note_len}) begin
          div_start_next = 1'b1;
          div_dvd_next   = DVD_W'(mag) * DVD_W'(note_len - elapsed);
          div_dvs_next   = FD_DVS;
          state_next     = S_FOUTW;
        end else begin
          state_next = S_STEP;
        end
      end
      S_FOUTW: begin
        if (div_rsp.done) begin
          mag_next   = div_rsp.quotient[14:0];
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        smp_next = neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
        if (({1'b0, elapsed} + 17'd1) >= {1'b0, note_len}) begin
          done_next   = 1'b1;
          active_next = 1'b0;
        end
        elapsed_next = elapsed + 16'd1;
        if (period_len != '0) begin
          if ((phase_count + 1'b1) == period_len) begin
            phase_count_next = '0;
          end else begin
            phase_count_next = phase_count + 1'b1;
          end
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_sample_next = smp;
          out_done_next   = done;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sts_div.sv
// bit-serial restoring divider, one quotient bit per clock
// depends on sts_pkg for widths and the request/response structs
`timescale 1ns / 1ps
`default_nettype none

module sts_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sts_pkg::div_req_t req,
  output sts_pkg::div_rsp_t      rsp
);
  import sts_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

>>> test/sine_tone_with_fade_unit_test.sv
// testbench for sine_tone_with_fade_unit: drives tick beats, predicts every
// faded sample and checks the sample beats; depends on sts_pkg, sts_if and the unit
`timescale 1ns / 1ps

typedef struct {
  logic signed [15:0] sample;
  logic               note_done;
} tone_beat_t;

class tone_sample_board;
  localparam int RATE_HZ = 16000;
  localparam int TABLE_PTS = 256;
  localparam int FADE_LEN = 128;
  localparam int AMPL_MAX = 32767;

  logic [13:0] phase_pos;
  logic [13:0] period;
  logic [15:0] played;
  logic [15:0] length;
  bit          rest;
  bit          playing;
  tone_beat_t  pending[$];
  int          errors;

  function new();
    phase_pos = '0;
    period = '0;
    played = '0;
    length = '0;
    rest = 0;
    playing = 0;
    errors = 0;
  endfunction

  function void note_tick(logic act, logic [12:0] freq, logic [11:0] dur);
    int         v;
    int         e;
    int         len;
    int         f;
    int         nl;
    bit         done;
    tone_beat_t beat;
    v = 0;
    done = 0;
    if (act) begin
      nl = (RATE_HZ * int'(dur)) / sts_pkg::MS_PER_S;
      if (nl > int'(sts_pkg::LEN_MAX)) nl = int'(sts_pkg::LEN_MAX);
      f = int'(freq);
      if (f > int'(sts_pkg::FREQ_MAX)) f = int'(sts_pkg::FREQ_MAX);
      length = nl[15:0];
      played = '0;
      phase_pos = '0;
      rest = (f == 0);
      period = rest ? 14'd0 : 14'(RATE_HZ / f);
      playing = (nl != 0);
      if (!playing) done = 1;
    end
    if (playing) begin
      if (!rest && period != 0) begin
        v = sts_pkg::SINE_PTS[(int'(phase_pos) * TABLE_PTS) / int'(period)];
        e = int'(played);
        len = int'(length);
        if (e < FADE_LEN) v = v * e / FADE_LEN;
        if (e > len - FADE_LEN) v = v * (len - e) / FADE_LEN;
        if (v > AMPL_MAX) v = AMPL_MAX;
        if (v < -AMPL_MAX) v = -AMPL_MAX;
      end
      if (int'(played) + 1 >= int'(length)) begin
        done = 1;
        playing = 0;
      end
      played = played + 16'd1;
      if (period != 0) phase_pos = 14'((int'(phase_pos) + 1) % int'(period));
    end
    beat.sample = v[15:0];
    beat.note_done = done;
    pending.push_back(beat);
  endfunction

  function void check_sample(logic signed [15:0] sample, logic note_done);
    tone_beat_t want;
    if (pending.size() == 0) begin
      $error("unexpected sample beat: sample %0d note_done %0b", sample, note_done);
      errors++;
    end else begin
      want = pending.pop_front();
      if (sample !== want.sample) begin
        $error("sample: expected %0d, actual %0d", want.sample, sample);
        errors++;
      end
      if (note_done !== want.note_done) begin
        $error("note_done: expected %0b, actual %0b", want.note_done, note_done);
        errors++;
      end
    end
  endfunction
endclass

module sine_tone_with_fade_unit_test;
  localparam int TICK_TARGET = 1250;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  logic clk;
  logic rst;
  int   ticks_sent;
  int   send_calm;

  sts_tick_if tick_ch ();
  sts_res_if  res_ch ();

  tone_sample_board sb;

  sine_tone_with_fade_unit dut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .result(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_tick(logic act, logic [12:0] freq, logic [11:0] dur);
    @(negedge clk);
    tick_ch.valid = 1'b1;
    tick_ch.action = act;
    tick_ch.freq_hz = freq;
    tick_ch.duration_ms = dur;
    do @(posedge clk); while (!tick_ch.ready);
    sb.note_tick(act, freq, dur);
    ticks_sent++;
  endtask

  task automatic tick_gap();
    int unsigned r;
    int gap;
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) send_calm = 40;
      else if (r < 60) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 50);
    end
    if (gap > 0) begin
      @(negedge clk);
      tick_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic next_sample();
    send_tick(1'b0, 13'($urandom), 12'($urandom));
    tick_gap();
  endtask

  task automatic start_note(logic [12:0] freq, logic [11:0] dur);
    send_tick(1'b1, freq, dur);
    tick_gap();
  endtask

  function automatic logic [12:0] pick_freq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 13'd0;
    if (r < 15) return 13'($urandom_range(8001, 8191));
    if (r < 35) return 13'($urandom);
    if (r < 55) return 13'($urandom_range(1, 200));
    return 13'($urandom_range(200, 2000));
  endfunction

  function automatic logic [11:0] pick_dur();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 12'($urandom_range(1, 12));
    if (r < 95) return 12'($urandom_range(13, 40));
    return 12'($urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_sample(res_ch.sample, res_ch.note_done);
  end

  initial begin
    int calm;
    int beats;
    res_ch.ready = 1'b0;
    calm = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      res_ch.ready = 1'b1;
      if (calm > 0) begin
        calm--;
        @(negedge clk);
      end else begin
        beats = $urandom_range(1, 8);
        repeat (beats) @(negedge clk);
        case ($urandom_range(0, 19))
          0: calm = 100;
          1: begin
            res_ch.ready = 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clk);
          end
          default: begin
            res_ch.ready = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
          end
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("sine_tone_with_fade_unit_test: FAIL");
    $finish;
  end

  initial begin
    int plan;
    int n;
    sb = new();
    ticks_sent = 0;
    send_calm = 0;
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.action = 1'b0;
    tick_ch.freq_hz = '0;
    tick_ch.duration_ms = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // idle, empty note with excess frequency, long note cut by restarts, rest
    send_tick(1'b0, 13'h1FFF, 12'hFFF);
    send_tick(1'b1, 13'h1FFF, 12'd0);
    send_tick(1'b0, 13'd0, 12'd0);
    start_note(13'h1FFF, 12'hFFF);
    repeat (2) next_sample();
    start_note(13'd1, 12'd1);
    repeat (2) next_sample();
    start_note(13'd0, 12'd1);
    while (sb.playing) next_sample();

    while (ticks_sent < TICK_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        next_sample();
      end else begin
        start_note(pick_freq(), pick_dur());
        plan = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : 32'h7FFF_FFFF;
        n = 0;
        while (sb.playing && n < plan && ticks_sent < TICK_TARGET) begin
          next_sample();
          n++;
        end
        repeat ($urandom_range(0, 2)) next_sample();
      end
    end

    @(negedge clk);
    tick_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d sample beats never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("sine_tone_with_fade_unit_test: PASS");
    end else begin
      $display("sine_tone_with_fade_unit_test: FAIL");
    end
    $finish;
  end
endmodule
